>>> design/jpdc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jpdc_pkg
// Shared types, register map and reset values of the joint PD torque control.
// ---------------------------------------------------------------------------
package jpdc_pkg;

  localparam int JOINTS_DEF  = 32;
  localparam int JOINT_W     = 5;
  localparam int ANGLE_W     = 32;
  localparam int GAIN_W      = 26;
  localparam int SPLIT_W     = 6;
  localparam int LIMIT_W     = 23;
  localparam int RATE_W      = 16;
  localparam int TORQUE_W    = 24;
  localparam int REG_ADDR_W  = 5;
  localparam int REG_DATA_W  = 32;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_STIFF_P = 3'd0;
  localparam logic [2:0] REG_STIFF_D = 3'd1;
  localparam logic [2:0] REG_SOFT_P  = 3'd2;
  localparam logic [2:0] REG_SOFT_D  = 3'd3;
  localparam logic [2:0] REG_SPLIT   = 3'd4;
  localparam logic [2:0] REG_LIMIT   = 3'd5;
  localparam logic [2:0] REG_RATE    = 3'd6;

  localparam logic [GAIN_W-1:0]  RST_STIFF_P = 26'd19660800;
  localparam logic [GAIN_W-1:0]  RST_STIFF_D = 26'd655360;
  localparam logic [GAIN_W-1:0]  RST_SOFT_P  = 26'd655360;
  localparam logic [GAIN_W-1:0]  RST_SOFT_D  = 26'd65536;
  localparam logic [SPLIT_W-1:0] RST_SPLIT   = 6'd24;
  localparam logic [LIMIT_W-1:0] RST_LIMIT   = 23'd2949120;
  localparam logic [RATE_W-1:0]  RST_RATE    = 16'd1000;

  localparam logic action_prime   = 1'b0;
  localparam logic action_control = 1'b1;

  typedef struct packed {
    logic [GAIN_W-1:0]  stiff_gain_p;
    logic [GAIN_W-1:0]  stiff_gain_d;
    logic [GAIN_W-1:0]  soft_gain_p;
    logic [GAIN_W-1:0]  soft_gain_d;
    logic [SPLIT_W-1:0] split_joint;
    logic [LIMIT_W-1:0] torque_limit;
    logic [RATE_W-1:0]  sample_rate;
  } cfg_t;

  typedef struct packed {
    logic                      action;
    logic [JOINT_W-1:0]        joint;
    logic signed [ANGLE_W-1:0] angle;
    logic signed [ANGLE_W-1:0] angle_ref;
    logic signed [ANGLE_W-1:0] velocity_ref;
  } item_t;

endpackage

>>> design/jpdc_ifs.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jpdc sample / result channels
// Valid-ready channels carrying one joint sample in and one torque out.
// ---------------------------------------------------------------------------
interface jpdc_sample_if
  import jpdc_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [JOINT_W-1:0]        joint;
  logic signed [ANGLE_W-1:0] angle;
  logic signed [ANGLE_W-1:0] angle_ref;
  logic signed [ANGLE_W-1:0] velocity_ref;

  modport source (output valid, action, joint, angle, angle_ref, velocity_ref,
                  input ready);
  modport sink (input valid, action, joint, angle, angle_ref, velocity_ref,
                output ready);
endinterface

interface jpdc_result_if
  import jpdc_pkg::*;
  ();
  logic                       valid;
  logic                       ready;
  logic [JOINT_W-1:0]         joint_out;
  logic signed [TORQUE_W-1:0] torque;
  logic                       clamped;

  modport source (output valid, joint_out, torque, clamped, input ready);
  modport sink (input valid, joint_out, torque, clamped, output ready);
endinterface

>>> design/jpdc_regs.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jpdc_regs
// APB register file holding gains, split joint, torque limit and sample rate.
// ---------------------------------------------------------------------------
module jpdc_regs
  import jpdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [REG_ADDR_W-1:0] paddr,
  input  logic [REG_DATA_W-1:0] pwdata,
  output logic [REG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [2:0] index;
  logic       wr;

  assign index  = paddr[REG_ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stiff_gain_p <= RST_STIFF_P;
      cfg.stiff_gain_d <= RST_STIFF_D;
      cfg.soft_gain_p  <= RST_SOFT_P;
      cfg.soft_gain_d  <= RST_SOFT_D;
      cfg.split_joint  <= RST_SPLIT;
      cfg.torque_limit <= RST_LIMIT;
      cfg.sample_rate  <= RST_RATE;
    end else if (wr) begin
      case (index)
        REG_STIFF_P: cfg.stiff_gain_p <= pwdata[GAIN_W-1:0];
        REG_STIFF_D: cfg.stiff_gain_d <= pwdata[GAIN_W-1:0];
        REG_SOFT_P:  cfg.soft_gain_p  <= pwdata[GAIN_W-1:0];
        REG_SOFT_D:  cfg.soft_gain_d  <= pwdata[GAIN_W-1:0];
        REG_SPLIT:   cfg.split_joint  <= pwdata[SPLIT_W-1:0];
        REG_LIMIT:   cfg.torque_limit <= pwdata[LIMIT_W-1:0];
        REG_RATE:    cfg.sample_rate  <= pwdata[RATE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_STIFF_P: prdata = REG_DATA_W'(cfg.stiff_gain_p);
      REG_STIFF_D: prdata = REG_DATA_W'(cfg.stiff_gain_d);
      REG_SOFT_P:  prdata = REG_DATA_W'(cfg.soft_gain_p);
      REG_SOFT_D:  prdata = REG_DATA_W'(cfg.soft_gain_d);
      REG_SPLIT:   prdata = REG_DATA_W'(cfg.split_joint);
      REG_LIMIT:   prdata = REG_DATA_W'(cfg.torque_limit);
      REG_RATE:    prdata = REG_DATA_W'(cfg.sample_rate);
      default:     prdata = '0;
    endcase
  end

endmodule

>>> design/jpdc_angle_mem.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jpdc_angle_mem
// Previous-angle store, one entry per joint, with per-entry valid bits.
// ---------------------------------------------------------------------------
module jpdc_angle_mem
  import jpdc_pkg::*;
#(
  parameter int DEPTH = JOINTS_DEF,
  parameter int AW    = 5
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic [AW-1:0]             addr,
  input  logic signed [ANGLE_W-1:0] wdata,
  output logic signed [ANGLE_W-1:0] rdata
);

  logic signed [ANGLE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]          valid;
  logic signed [ANGLE_W-1:0] rd_q;
  logic                      rd_valid;

  // read returns the old entry; the same request writes its own angle back
  always_ff @(posedge clk) begin
    if (en) begin
      rd_q     <= mem[addr];
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else if (en) begin
      rd_valid    <= valid[addr];
      valid[addr] <= 1'b1;
    end
  end

  assign rdata = rd_valid ? rd_q : '0;

endmodule

>>> design/jpdc_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jpdc_datapath
// Eight-stage PD torque pipeline: velocity, gain products, rounding, clamp.
// ---------------------------------------------------------------------------
module jpdc_datapath
  import jpdc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  cfg_t                       cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  item_t                      item,
  input  logic                       in_range,
  input  logic signed [ANGLE_W-1:0]  prev_angle,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [JOINT_W-1:0]         joint_out,
  output logic signed [TORQUE_W-1:0] torque,
  output logic                       clamped
);

  localparam int STAGES = 8;

  logic [STAGES:1] vld;
  logic [STAGES:1] ld;

  always_comb begin
    ld[STAGES] = !vld[STAGES] || out_ready;
    for (int k = STAGES - 1; k >= 1; k--) begin
      ld[k] = !vld[k] || ld[k+1];
    end
  end

  assign in_ready  = ld[1];
  assign out_valid = vld[STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ld[1]) vld[1] <= in_valid;
      for (int k = 2; k <= STAGES; k++) begin
        if (ld[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // stage 1: item registered alongside the memory read
  logic a1, r1;
  logic [JOINT_W-1:0] j1;
  logic signed [ANGLE_W-1:0] q1, qr1, vr1;

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      a1  <= item.action;
      j1  <= item.joint;
      q1  <= item.angle;
      qr1 <= item.angle_ref;
      vr1 <= item.velocity_ref;
      r1  <= in_range;
    end
  end

  logic signed [ANGLE_W-1:0] q_old;
  logic signed [ANGLE_W:0]   diff1, err1;
  logic                      stiff1;

  always_comb begin
    q_old  = r1 ? prev_angle : '0;
    diff1  = {q1[ANGLE_W-1], q1} - {q_old[ANGLE_W-1], q_old};
    err1   = {q1[ANGLE_W-1], q1} - {qr1[ANGLE_W-1], qr1};
    stiff1 = {1'b0, j1} < cfg.split_joint;
  end

  // stage 2: products for velocity and position term
  logic a2;
  logic [JOINT_W-1:0] j2;
  logic signed [ANGLE_W:0] diff2, err2;
  logic signed [ANGLE_W-1:0] vr2;
  logic [GAIN_W-1:0] kp2, kd2;

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      a2    <= a1;
      j2    <= j1;
      diff2 <= diff1;
      err2  <= err1;
      vr2   <= vr1;
      kp2   <= stiff1 ? cfg.stiff_gain_p : cfg.soft_gain_p;
      kd2   <= stiff1 ? cfg.stiff_gain_d : cfg.soft_gain_d;
    end
  end

  localparam int DQ_W = ANGLE_W + 1 + RATE_W + 1;
  localparam int PR_W = ANGLE_W + 1 + GAIN_W + 1;

  logic signed [DQ_W-1:0] dq_raw2;
  logic signed [PR_W-1:0] pterm2;

  always_comb begin
    dq_raw2 = diff2 * $signed({1'b0, cfg.sample_rate});
    pterm2  = err2 * $signed({1'b0, kp2});
  end

  // stage 3: saturate velocity, velocity error
  logic a3;
  logic [JOINT_W-1:0] j3;
  logic signed [DQ_W-1:0] dq_raw3;
  logic signed [PR_W-1:0] p3;
  logic signed [ANGLE_W-1:0] vr3;
  logic [GAIN_W-1:0] kd3;

  always_ff @(posedge clk) begin
    if (ld[3]) begin
      a3      <= a2;
      j3      <= j2;
      dq_raw3 <= dq_raw2;
      p3      <= pterm2;
      vr3     <= vr2;
      kd3     <= kd2;
    end
  end

  logic [DQ_W-ANGLE_W:0]     dq_hi;
  logic signed [ANGLE_W-1:0] dq3;
  logic signed [ANGLE_W:0]   ve3;

  always_comb begin
    dq_hi = dq_raw3[DQ_W-1:ANGLE_W-1];
    if ((&dq_hi) || !(|dq_hi)) begin
      dq3 = dq_raw3[ANGLE_W-1:0];
    end else if (dq_raw3[DQ_W-1]) begin
      dq3 = {1'b1, {(ANGLE_W-1){1'b0}}};
    end else begin
      dq3 = {1'b0, {(ANGLE_W-1){1'b1}}};
    end
    ve3 = {dq3[ANGLE_W-1], dq3} - {vr3[ANGLE_W-1], vr3};
  end

  // stage 4: velocity term product
  logic a4;
  logic [JOINT_W-1:0] j4;
  logic signed [PR_W-1:0] p4;
  logic signed [ANGLE_W:0] ve4;
  logic [GAIN_W-1:0] kd4;

  always_ff @(posedge clk) begin
    if (ld[4]) begin
      a4  <= a3;
      j4  <= j3;
      p4  <= p3;
      ve4 <= ve3;
      kd4 <= kd3;
    end
  end

  logic signed [PR_W-1:0] dterm4;
  assign dterm4 = ve4 * $signed({1'b0, kd4});

  // stage 5: sum of terms
  logic a5;
  logic [JOINT_W-1:0] j5;
  logic signed [PR_W-1:0] p5, d5;

  always_ff @(posedge clk) begin
    if (ld[5]) begin
      a5 <= a4;
      j5 <= j4;
      p5 <= p4;
      d5 <= dterm4;
    end
  end

  logic signed [PR_W:0] sum5;
  assign sum5 = {p5[PR_W-1], p5} + {d5[PR_W-1], d5};

  // stage 6: negate and round to Q.16, ties up: -sum + 2^15 = ~sum + 2^15 + 1
  logic a6;
  logic [JOINT_W-1:0] j6;
  logic signed [PR_W:0] sum6;

  always_ff @(posedge clk) begin
    if (ld[6]) begin
      a6   <= a5;
      j6   <= j5;
      sum6 <= sum5;
    end
  end

  localparam int TAU_W = PR_W + 1 - 16;

  logic [PR_W:0] rnd6;
  assign rnd6 = ~sum6 + (PR_W + 1)'(32769);

  // stage 7: clamp against the limit; prime requests give zero torque
  logic a7;
  logic [JOINT_W-1:0] j7;
  logic signed [TAU_W-1:0] t7;

  always_ff @(posedge clk) begin
    if (ld[7]) begin
      a7 <= a6;
      j7 <= j6;
      t7 <= rnd6[PR_W:16];
    end
  end

  logic signed [TAU_W-1:0]    lim, nlim;
  logic signed [TORQUE_W-1:0] tq7;
  logic                       cl7;

  always_comb begin
    lim  = $signed(TAU_W'(cfg.torque_limit));
    nlim = -lim;
    tq7  = t7[TORQUE_W-1:0];
    cl7  = 1'b0;
    if (a7 == action_prime) begin
      tq7 = '0;
    end else if (t7 > lim) begin
      tq7 = lim[TORQUE_W-1:0];
      cl7 = 1'b1;
    end else if (t7 < nlim) begin
      tq7 = nlim[TORQUE_W-1:0];
      cl7 = 1'b1;
    end
  end

  // stage 8: output register
  always_ff @(posedge clk) begin
    if (ld[8]) begin
      joint_out <= j7;
      torque    <= tq7;
      clamped   <= cl7;
    end
  end

endmodule

>>> design/joint_pd_torque_control.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// joint_pd_torque_control
// Per-joint PD torque controller with symmetric torque saturation.
// ---------------------------------------------------------------------------
// Takes one joint sample per cycle while the result side keeps up, and
// returns one torque per sample, in order, from the datapath pipeline. The
// previous angle of each joint sits in a one-port-per-cycle memory that is
// read and rewritten in the accept cycle, so samples for the same joint may
// follow each other back to back. Entries read as zero until the joint is
// first seen after reset; no clearing pass is needed. Prime requests return
// zero torque. The user writes gains, split joint, limit and sample rate over
// APB only while the block is idle; the block itself does not enforce this.
module joint_pd_torque_control
  import jpdc_pkg::*;
#(
  parameter int JOINTS = JOINTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  jpdc_sample_if.sink           sample,
  jpdc_result_if.source         result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [REG_ADDR_W-1:0] paddr,
  input  logic [REG_DATA_W-1:0] pwdata,
  output logic [REG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int AW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

  cfg_t                      cfg;
  item_t                     item;
  logic                      accept;
  logic                      in_range;
  logic                      mem_en;
  logic signed [ANGLE_W-1:0] prev_angle;

  assign item.action       = sample.action;
  assign item.joint        = sample.joint;
  assign item.angle        = sample.angle;
  assign item.angle_ref    = sample.angle_ref;
  assign item.velocity_ref = sample.velocity_ref;

  assign accept   = sample.valid && sample.ready;
  assign in_range = 32'(sample.joint) < 32'(JOINTS);
  assign mem_en   = accept && in_range;

  jpdc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  jpdc_angle_mem #(
    .DEPTH (JOINTS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .rst   (rst),
    .en    (mem_en),
    .addr  (AW'(sample.joint)),
    .wdata (sample.angle),
    .rdata (prev_angle)
  );

  jpdc_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (sample.valid),
    .in_ready   (sample.ready),
    .item       (item),
    .in_range   (in_range),
    .prev_angle (prev_angle),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .joint_out  (result.joint_out),
    .torque     (result.torque),
    .clamped    (result.clamped)
  );

endmodule

>>> design/jpdc_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jpdc_checker
// Port-level checks of the joint PD torque control, bound to the top level.
// ---------------------------------------------------------------------------
module jpdc_checker
  import jpdc_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  sample_valid,
  input logic                  sample_ready,
  input logic                  result_valid,
  input logic                  result_ready,
  input logic [JOINT_W-1:0]    joint_out,
  input logic [TORQUE_W-1:0]   torque,
  input logic                  clamped,
  input logic                  psel,
  input logic                  penable,
  input logic                  pwrite,
  input logic [REG_ADDR_W-1:0] paddr,
  input logic [REG_DATA_W-1:0] pwdata,
  input logic [REG_DATA_W-1:0] prdata
);

  localparam int PIPE_DEPTH = 8;

  logic [3:0] pend;
  logic       acc_in, acc_out, split_wr;

  assign acc_in   = sample_valid && sample_ready;
  assign acc_out  = result_valid && result_ready;
  assign split_wr = psel && penable && pwrite && (paddr[REG_ADDR_W-1:2] == REG_SPLIT);

  // requests in flight, seen from the ports
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (acc_in && !acc_out) begin
      pend <= pend + 4'd1;
    end else if (!acc_in && acc_out) begin
      pend <= pend - 4'd1;
    end
  end

  a_reset_clears: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> pend != 4'd0)
    else $error("result without an accepted request");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    pend <= 4'(PIPE_DEPTH))
    else $error("more requests in flight than pipeline stages");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(joint_out) && $stable(torque) && $stable(clamped))
    else $error("stalled result changed");

  a_split_readback: assert property (@(posedge clk) disable iff (rst)
    split_wr ##1 (paddr == $past(paddr)) |->
      prdata == REG_DATA_W'($past(pwdata[SPLIT_W-1:0])))
    else $error("split joint readback mismatch");

endmodule

bind joint_pd_torque_control jpdc_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample.valid),
  .sample_ready (sample.ready),
  .result_valid (result.valid),
  .result_ready (result.ready),
  .joint_out    (result.joint_out),
  .torque       (result.torque),
  .clamped      (result.clamped),
  .psel         (psel),
  .penable      (penable),
  .pwrite       (pwrite),
  .paddr        (paddr),
  .pwdata       (pwdata),
  .prdata       (prdata)
);

>>> tb/jpdc_torque_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// jpdc_torque_checker
// Watches the sample, result and APB ports of the joint PD torque control,
// keeps its own copy of the registers and previous angles, predicts each
// torque and compares it, in order, with what the block returns.
// ---------------------------------------------------------------------------
module jpdc_torque_checker
  import jpdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  jpdc_sample_if                smp,
  jpdc_result_if                res,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [REG_ADDR_W-1:0] paddr,
  input  logic [REG_DATA_W-1:0] pwdata,
  output int                    mismatches,
  output int                    pending,
  output int                    checked,
  output int                    clamps
);

  typedef struct packed {
    logic [JOINT_W-1:0]         joint;
    logic signed [TORQUE_W-1:0] torque;
    logic                       clamped;
  } torque_t;

  localparam longint VEL_MAX = 64'sd2147483647;
  localparam longint VEL_MIN = -64'sd2147483648;

  cfg_t                      regs;
  logic signed [ANGLE_W-1:0] prev_angle [JOINTS_DEF];
  torque_t                   torque_q [$];
  torque_t                   want;
  torque_t                   got;
  item_t                     req;
  int                        mism_n;
  int                        checked_n;
  int                        clamp_n;

  // PD law: tau = -(q - q_ref) * Kp - (dq - dq_ref) * Kd, Q.32 products,
  // rounded to Q.16 with ties toward +inf, then clamped to +/- limit
  function automatic torque_t pd_torque(input item_t it, input logic signed [31:0] prev);
    torque_t r;
    longint  ang;
    longint  vel;
    longint  kp;
    longint  kd;
    longint  sum;
    longint  tau;
    longint  lim;
    logic    stiff;
    r.joint   = it.joint;
    r.torque  = '0;
    r.clamped = 1'b0;
    if (it.action == action_prime) begin
      return r;
    end
    ang = longint'($signed(it.angle));
    vel = (ang - longint'(prev)) * longint'(regs.sample_rate);
    if (vel > VEL_MAX) vel = VEL_MAX;
    if (vel < VEL_MIN) vel = VEL_MIN;
    stiff = {1'b0, it.joint} < regs.split_joint;
    kp  = stiff ? longint'(regs.stiff_gain_p) : longint'(regs.soft_gain_p);
    kd  = stiff ? longint'(regs.stiff_gain_d) : longint'(regs.soft_gain_d);
    sum = (ang - longint'($signed(it.angle_ref))) * kp
        + (vel - longint'($signed(it.velocity_ref))) * kd;
    tau = (64'sd32768 - sum) >>> 16;
    lim = longint'(regs.torque_limit);
    if (tau > lim) begin
      tau = lim;
      r.clamped = 1'b1;
    end
    if (tau < -lim) begin
      tau = -lim;
      r.clamped = 1'b1;
    end
    r.torque = tau[TORQUE_W-1:0];
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input longint exp_v, input longint act_v);
    mism_n++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
  endtask

  initial begin
    mism_n    = 0;
    checked_n = 0;
    clamp_n   = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      regs.stiff_gain_p = RST_STIFF_P;
      regs.stiff_gain_d = RST_STIFF_D;
      regs.soft_gain_p  = RST_SOFT_P;
      regs.soft_gain_d  = RST_SOFT_D;
      regs.split_joint  = RST_SPLIT;
      regs.torque_limit = RST_LIMIT;
      regs.sample_rate  = RST_RATE;
      prev_angle = '{default: '0};
      torque_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_STIFF_P: regs.stiff_gain_p = pwdata[GAIN_W-1:0];
          REG_STIFF_D: regs.stiff_gain_d = pwdata[GAIN_W-1:0];
          REG_SOFT_P:  regs.soft_gain_p  = pwdata[GAIN_W-1:0];
          REG_SOFT_D:  regs.soft_gain_d  = pwdata[GAIN_W-1:0];
          REG_SPLIT:   regs.split_joint  = pwdata[SPLIT_W-1:0];
          REG_LIMIT:   regs.torque_limit = pwdata[LIMIT_W-1:0];
          REG_RATE:    regs.sample_rate  = pwdata[RATE_W-1:0];
          default: ;
        endcase
      end
      if (smp.valid && smp.ready) begin
        req.action       = smp.action;
        req.joint        = smp.joint;
        req.angle        = smp.angle;
        req.angle_ref    = smp.angle_ref;
        req.velocity_ref = smp.velocity_ref;
        torque_q.push_back(pd_torque(req, prev_angle[req.joint]));
        // both prime and control leave the measured angle behind
        prev_angle[req.joint] = req.angle;
      end
      if (res.valid && res.ready) begin
        got.joint   = res.joint_out;
        got.torque  = res.torque;
        got.clamped = res.clamped;
        if (torque_q.size() == 0) begin
          mism_n++;
          $display("%0t: unexpected result, joint %0d torque %0d", $time, got.joint,
                   got.torque);
        end else begin
          want = torque_q.pop_front();
          checked_n++;
          if (want.clamped) clamp_n++;
          if (got.joint !== want.joint)
            flag_mismatch("joint_out", longint'(want.joint), longint'(got.joint));
          if (got.torque !== want.torque)
            flag_mismatch("torque", longint'(want.torque), longint'(got.torque));
          if (got.clamped !== want.clamped)
            flag_mismatch("clamped", longint'(want.clamped), longint'(got.clamped));
        end
      end
    end
    pending    <= torque_q.size();
    mismatches <= mism_n;
    checked    <= checked_n;
    clamps     <= clamp_n;
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives joint samples and register settings into the joint PD torque
// control with random gaps and result stalls; the checker predicts and
// compares every torque, and this top gives the verdict.
// ---------------------------------------------------------------------------
module testbench;
  import jpdc_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int PHASE_ITEMS     = 125;
  localparam int RANDOM_PHASES   = 8;
  localparam logic [GAIN_W-1:0]  GAIN_MAX  = '1;
  localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;
  localparam logic [RATE_W-1:0]  RATE_MAX  = '1;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [REG_ADDR_W-1:0] paddr;
  logic [REG_DATA_W-1:0] pwdata;
  logic [REG_DATA_W-1:0] prdata;
  logic                  pready;

  int   mismatches;
  int   pending;
  int   checked;
  int   clamps;
  int   cycle_count;
  int   n_prime;
  int   n_control;
  int   n_settings;
  logic no_idle;

  jpdc_sample_if smp ();
  jpdc_result_if res ();

  joint_pd_torque_control u_dut (
    .clk     (clk),
    .rst     (rst),
    .sample  (smp),
    .result  (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  jpdc_torque_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .smp        (smp),
    .res        (res),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked),
    .clamps     (clamps)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
    $display("testbench: errors");
    $finish;
  end

  function automatic item_t mk(input logic act, input int jnt, input logic [31:0] ang,
                               input logic [31:0] aref, input logic [31:0] vref);
    item_t it;
    it.action       = act;
    it.joint        = JOINT_W'(jnt);
    it.angle        = ang;
    it.angle_ref    = aref;
    it.velocity_ref = vref;
    return it;
  endfunction

  // mostly small angles so torques land below the limit, some full-range noise
  function automatic item_t rand_item();
    item_t it;
    it.action = ($urandom_range(0, 3) == 0) ? action_prime : action_control;
    it.joint  = JOINT_W'($urandom_range(0, 31));
    if ($urandom_range(0, 3) == 0) begin
      it.angle        = $urandom;
      it.angle_ref    = $urandom;
      it.velocity_ref = $urandom;
    end else begin
      it.angle        = int'($urandom_range(0, 4095)) - 2048;
      it.angle_ref    = it.angle + (int'($urandom_range(0, 1023)) - 512);
      it.velocity_ref = int'($urandom_range(0, 1 << 18)) - (1 << 17);
    end
    return it;
  endfunction

  function automatic logic [GAIN_W-1:0] rand_gain();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return GAIN_MAX;
      2:       return GAIN_W'($urandom);
      default: return GAIN_W'($urandom_range(0, 1 << 20));
    endcase
  endfunction

  function automatic cfg_t rand_cfg();
    cfg_t c;
    c.stiff_gain_p = rand_gain();
    c.stiff_gain_d = rand_gain();
    c.soft_gain_p  = rand_gain();
    c.soft_gain_d  = rand_gain();
    case ($urandom_range(0, 5))
      0:       c.split_joint = '0;
      1:       c.split_joint = SPLIT_W'(32);
      2:       c.split_joint = '1;
      default: c.split_joint = SPLIT_W'($urandom_range(1, 31));
    endcase
    case ($urandom_range(0, 4))
      0:       c.torque_limit = '0;
      1:       c.torque_limit = LIMIT_MAX;
      2:       c.torque_limit = LIMIT_W'($urandom);
      default: c.torque_limit = LIMIT_W'($urandom_range(1 << 14, 1 << 22));
    endcase
    case ($urandom_range(0, 4))
      0:       c.sample_rate = '0;
      1:       c.sample_rate = RATE_W'(1);
      2:       c.sample_rate = RATE_MAX;
      default: c.sample_rate = RATE_W'($urandom_range(1, 2000));
    endcase
    return c;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [REG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_cfg(input cfg_t c);
    write_reg(REG_STIFF_P, REG_DATA_W'(c.stiff_gain_p));
    write_reg(REG_STIFF_D, REG_DATA_W'(c.stiff_gain_d));
    write_reg(REG_SOFT_P,  REG_DATA_W'(c.soft_gain_p));
    write_reg(REG_SOFT_D,  REG_DATA_W'(c.soft_gain_d));
    write_reg(REG_SPLIT,   REG_DATA_W'(c.split_joint));
    write_reg(REG_LIMIT,   REG_DATA_W'(c.torque_limit));
    write_reg(REG_RATE,    REG_DATA_W'(c.sample_rate));
    n_settings++;
  endtask

  // valid stays high across back-to-back requests
  task automatic send(input item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      smp.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    smp.valid        <= 1'b1;
    smp.action       <= it.action;
    smp.joint        <= it.joint;
    smp.angle        <= it.angle;
    smp.angle_ref    <= it.angle_ref;
    smp.velocity_ref <= it.velocity_ref;
    do @(posedge clk); while (!smp.ready);
    if (it.action == action_prime) n_prime++;
    else n_control++;
  endtask

  // called on the edge of the last accepted request
  task automatic drain();
    smp.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  initial begin
    res.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (res.valid && res.ready) begin
        int stall;
        stall = no_idle ? 0 : $urandom_range(0, 17);
        if (stall > 0) begin
          res.ready <= 1'b0;
          repeat (stall) @(posedge clk);
          res.ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    cfg_t c;
    rst              <= 1'b1;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    smp.valid        <= 1'b0;
    smp.action       <= action_prime;
    smp.joint        <= '0;
    smp.angle        <= '0;
    smp.angle_ref    <= '0;
    smp.velocity_ref <= '0;
    no_idle    = 1'b0;
    n_prime    = 0;
    n_control  = 0;
    n_settings = 1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part under reset settings (split at 24)
    send(mk(action_prime,   0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
    send(mk(action_control, 0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
    send(mk(action_control, 0, 32'h0000_1000, 32'h0000_0000, 32'h0000_0000));
    send(mk(action_prime,  31, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000));
    // huge angle steps: velocity saturates low, then high
    send(mk(action_control, 31, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    send(mk(action_control, 31, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    // never primed joints read zero; stiff / soft boundary
    send(mk(action_control, 23, 32'h0000_0064, 32'h0000_0000, 32'h0000_0000));
    send(mk(action_control, 24, 32'h0000_0064, 32'h0000_0000, 32'h0000_0000));
    send(mk(action_prime,   5, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000));
    send(mk(action_control, 5, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000));
    send(mk(action_control, 5, 32'h8000_0100, 32'h8000_0000, 32'h0001_0000));
    send(mk(action_control, 1, 32'h0000_0020, 32'h0000_0040, 32'hFFFF_FF00));
    send(mk(action_prime,   1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send(mk(action_control, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
    send(mk(action_control, 30, 32'h0000_0000, 32'h0000_0000, 32'h8000_0000));
    send(mk(action_prime,  31, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
    send(mk(action_control, 31, 32'h0000_0001, 32'h0000_0000, 32'h0000_0000));
    send(mk(action_control, 31, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000));
    drain();

    for (int p = 1; p <= RANDOM_PHASES; p++) begin
      no_idle = (p == 4 || p == 7);
      c = rand_cfg();
      if (p == 1) begin
        c = '{GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, SPLIT_W'(32), LIMIT_MAX, RATE_MAX};
      end else if (p == 2) begin
        // zero limit, zero rate, every joint on the soft pair
        c.split_joint  = '0;
        c.torque_limit = '0;
        c.sample_rate  = '0;
      end else if (p == 3) begin
        // unit position gain exposes the rounding of half steps
        c = '{GAIN_W'(1), '0, GAIN_W'(1), '0, '1, LIMIT_W'(100), RATE_W'(1)};
      end
      load_cfg(c);
      if (p == 3) begin
        send(mk(action_control, 3, 32'h0000_0000, 32'h0000_8000, 32'h0000_0000));
        send(mk(action_control, 3, 32'h0000_8000, 32'h0000_0000, 32'h0000_0000));
        send(mk(action_control, 3, 32'h0001_8000, 32'h0000_0000, 32'h0000_0000));
        send(mk(action_control, 3, 32'h0000_0000, 32'h0001_8000, 32'h0000_0000));
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send(rand_item());
      end
      drain();
    end

    $display("run covered %0d prime and %0d control samples under %0d register settings",
             n_prime, n_control, n_settings);
    $display("%0d torques checked, %0d of them clamped", checked, clamps);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

>>> joint_pd_torque_control.f
design/jpdc_pkg.sv
design/jpdc_ifs.sv
design/jpdc_regs.sv
design/jpdc_angle_mem.sv
design/jpdc_datapath.sv
design/joint_pd_torque_control.sv
design/jpdc_checker.sv
tb/jpdc_torque_checker.sv
tb/testbench.sv
